@@ design/dwpb_pkg.sv @@
package dwpb_pkg;

   // Largest image dimension accepted; larger register writes saturate to it.
   localparam int MAX_DIM = 4096;

   localparam int COORD_W = 12;
   localparam int DIM_W = 13;
   localparam int PIX_W = 16;
   localparam int WGT_W = 12;               // distance to the nearer edge, <= MAX_DIM/2
   localparam int DEN_W = WGT_W + 1;
   localparam int NUM_W = PIX_W + WGT_W;    // x*a + y*b stays below 2^NUM_W
   localparam int QUO_W = PIX_W;
   localparam int DIV_BITS = 4;             // quotient bits resolved per divider stage
   localparam int DIV_STAGES = QUO_W / DIV_BITS;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_ROWS = 1'b0,
      CSR_IMAGE_COLS = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
   } dims_type;

   typedef struct packed {
      logic             err;
      logic [WGT_W-1:0] wa;
      logic [WGT_W-1:0] wb;
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
   } wgt_type;

   typedef struct packed {
      logic             err;
      logic [NUM_W-1:0] pa;
      logic [NUM_W-1:0] pb;
      logic [DEN_W-1:0] den;
   } prod_type;

   typedef struct packed {
      logic             err;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [PIX_W-1:0] num_lo;
      logic [QUO_W-1:0] quo;
   } div_type;

endpackage

@@ design/dwpb_req_if.sv @@
interface dwpb_req_if;
   import dwpb_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic [PIX_W-1:0]   horiz_pixel;
   logic [PIX_W-1:0]   vert_pixel;

   modport source(output valid, row, col, horiz_pixel, vert_pixel, input ready);
   modport sink(input valid, row, col, horiz_pixel, vert_pixel, output ready);
endinterface

@@ design/dwpb_rsp_if.sv @@
interface dwpb_rsp_if;
   import dwpb_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blended_pixel;
   logic             coord_error;

   modport source(output valid, blended_pixel, coord_error, input ready);
   modport sink(input valid, blended_pixel, coord_error, output ready);
endinterface

@@ design/dwpb_csr_if.sv @@
interface dwpb_csr_if;
   import dwpb_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ design/diagonal_weight_pixel_blend_unit.sv @@
// Diagonal position-weighted blend of a horizontally and a vertically blended pixel.
//
// req_chan : one beat per pixel: row, col, horiz_pixel, vert_pixel.
// rsp_chan : one beat per request beat, in order: blended_pixel, coord_error.
// csr_chan : register writes, index 0 = image_rows, 1 = image_cols; always ready.
//            Write only while no pixel is in flight. Values above MAX_DIM saturate.
//
// Pipeline: a request beat accepted on req_chan passes through seven register stages
// (weight, product, sum, four 4-bit divider stages) before it shows on rsp_chan.
// Throughput: one beat per clock; the length of the pipeline sets the latency,
// the single-stage handshake lets a beat enter every cycle while rsp_chan drains.
//
// The pipeline moves as one: when the output beat waits on rsp_chan.ready the
// whole pipeline holds and req_chan.ready drops in the same cycle; bubbles ahead
// of a stalled output are not squeezed out.
// Reset (synchronous) empties the pipeline and sets both image sizes to MAX_DIM.
module diagonal_weight_pixel_blend_unit (
   input logic      clock,
   input logic      reset,
   dwpb_req_if.sink req_chan,
   dwpb_rsp_if.source rsp_chan,
   dwpb_csr_if.sink csr_chan
);
   import dwpb_pkg::*;

   dims_type dims;
   logic     en;
   logic     wgt_valid;
   wgt_type  wgt_data;
   logic     div_valid [DIV_STAGES+1];
   div_type  div_data  [DIV_STAGES+1];

   // global advance: the last stage is free or being drained this cycle
   assign en = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   dwpb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .dims     (dims)
   );

   dwpb_wgt u_wgt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_chan.valid),
      .row         (req_chan.row),
      .col         (req_chan.col),
      .horiz_pixel (req_chan.horiz_pixel),
      .vert_pixel  (req_chan.vert_pixel),
      .dims        (dims),
      .out_valid   (wgt_valid),
      .out_data    (wgt_data)
   );

   dwpb_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (wgt_valid),
      .in_data   (wgt_data),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0])
   );

   // divider chain, most significant quotient bits first
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      dwpb_div u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   // error beats carry a zero quotient, so no masking here
   assign rsp_chan.valid = div_valid[DIV_STAGES];
   assign rsp_chan.blended_pixel = div_data[DIV_STAGES].quo;
   assign rsp_chan.coord_error = div_data[DIV_STAGES].err;

   a_dims_bounded: assert property (@(posedge clock) disable iff (reset)
      dims.rows <= DIM_W'(MAX_DIM) && dims.cols <= DIM_W'(MAX_DIM))
      else $error("image size register above MAX_DIM");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.coord_error |-> rsp_chan.blended_pixel == '0)
      else $error("out-of-image beat with nonzero pixel");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      wgt_valid |-> (wgt_data.wa != '0 || wgt_data.wb != '0))
      else $error("zero weight sum entering divider");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      div_valid[DIV_STAGES] |-> div_data[DIV_STAGES].rem < div_data[DIV_STAGES].den)
      else $error("divider remainder not below divisor");
endmodule

@@ design/dwpb_csr.sv @@
module dwpb_csr (
   input  logic              clock,
   input  logic              reset,
   dwpb_csr_if.sink          csr_chan,
   output dwpb_pkg::dims_type dims
);
   import dwpb_pkg::*;

   dims_type         dims_ff;
   dims_type         dims_in;
   logic [DIM_W-1:0] clamped;

   assign csr_chan.ready = 1'b1;

   // saturate to the largest supported dimension
   assign clamped = (csr_chan.data > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : csr_chan.data;

   always_comb begin
      dims_in = dims_ff;
      if (csr_chan.valid) begin
         case (csr_idx_type'(csr_chan.index))
            CSR_IMAGE_ROWS: dims_in.rows = clamped;
            CSR_IMAGE_COLS: dims_in.cols = clamped;
            default: dims_in = dims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.rows <= DIM_W'(MAX_DIM);
         dims_ff.cols <= DIM_W'(MAX_DIM);
      end else begin
         dims_ff <= dims_in;
      end
   end

   assign dims = dims_ff;
endmodule

@@ design/dwpb_wgt.sv @@
module dwpb_wgt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [dwpb_pkg::COORD_W-1:0]  row,
   input  logic [dwpb_pkg::COORD_W-1:0]  col,
   input  logic [dwpb_pkg::PIX_W-1:0]    horiz_pixel,
   input  logic [dwpb_pkg::PIX_W-1:0]    vert_pixel,
   input  dwpb_pkg::dims_type            dims,
   output logic                          out_valid,
   output dwpb_pkg::wgt_type             out_data
);
   import dwpb_pkg::*;

   logic             valid_ff;
   wgt_type          wgt_ff;
   wgt_type          wgt_in;
   logic [DIM_W-1:0] r;
   logic [DIM_W-1:0] c;
   logic [DIM_W-1:0] a;
   logic [DIM_W-1:0] b;

   assign r = DIM_W'(row);
   assign c = DIM_W'(col);

   // distance to the nearer edge; the middle row/col belongs to the top/left half
   assign a = (r <= (dims.rows >> 1)) ? r : dims.rows - r;
   assign b = (c <= (dims.cols >> 1)) ? c : dims.cols - c;

   always_comb begin
      wgt_in.err = (r >= dims.rows) || (c >= dims.cols);
      wgt_in.wa = a[WGT_W-1:0];
      wgt_in.wb = b[WGT_W-1:0];
      wgt_in.x = horiz_pixel;
      wgt_in.y = vert_pixel;
      if (wgt_in.err) begin
         // 0 / 1 gives the zero result for out-of-image pixels
         wgt_in.wa = WGT_W'(1);
         wgt_in.wb = '0;
         wgt_in.x = '0;
      end else if (a == '0 && b == '0) begin
         // top-left corner: full weight on the horizontal pixel
         wgt_in.wa = WGT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wgt_ff <= wgt_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = wgt_ff;
endmodule

@@ design/dwpb_mul.sv @@
module dwpb_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  dwpb_pkg::wgt_type in_data,
   output logic              out_valid,
   output dwpb_pkg::div_type out_data
);
   import dwpb_pkg::*;

   logic             prod_valid_ff;
   prod_type         prod_ff;
   prod_type         prod_in;
   logic             sum_valid_ff;
   div_type          sum_ff;
   div_type          sum_in;
   logic [NUM_W-1:0] num;

   // stage 1: two independent products and the weight sum
   always_comb begin
      prod_in.err = in_data.err;
      prod_in.pa = NUM_W'(in_data.x) * NUM_W'(in_data.wa);
      prod_in.pb = NUM_W'(in_data.y) * NUM_W'(in_data.wb);
      prod_in.den = DEN_W'(in_data.wa) + DEN_W'(in_data.wb);
   end

   // stage 2: numerator, split into divider seed and remaining low bits
   assign num = prod_ff.pa + prod_ff.pb;

   always_comb begin
      sum_in.err = prod_ff.err;
      sum_in.den = prod_ff.den;
      sum_in.rem = DEN_W'(num[NUM_W-1:QUO_W]);
      sum_in.num_lo = num[QUO_W-1:0];
      sum_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
         sum_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_data = sum_ff;
endmodule

@@ design/dwpb_div.sv @@
module dwpb_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  dwpb_pkg::div_type in_data,
   output logic              out_valid,
   output dwpb_pkg::div_type out_data
);
   import dwpb_pkg::*;

   logic             valid_ff;
   div_type          div_ff;
   div_type          div_in;
   logic [DEN_W-1:0] trial;

   // restoring division, DIV_BITS quotient bits per stage; rem < den holds throughout
   always_comb begin
      div_in = in_data;
      trial = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {div_in.rem[DEN_W-2:0], div_in.num_lo[PIX_W-1]};
         div_in.num_lo = {div_in.num_lo[PIX_W-2:0], 1'b0};
         if (trial >= div_in.den) begin
            div_in.rem = trial - div_in.den;
            div_in.quo = {div_in.quo[QUO_W-2:0], 1'b1};
         end else begin
            div_in.rem = trial;
            div_in.quo = {div_in.quo[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = div_ff;
endmodule

@@ bench/tb.sv @@
module tb;
   import dwpb_pkg::*;

   // One pixel pair as it travels on the request channel.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   horiz;
      logic [PIX_W-1:0]   vert;
   } pixel_pair_type;

   // Predicted blend, kept with its source pair for mismatch reports.
   typedef struct packed {
      pixel_pair_type   src;
      logic [PIX_W-1:0] pixel;
      logic             err;
   } blend_result_type;

   logic clock = 1'b0;
   logic reset;

   dwpb_req_if req_bus();
   dwpb_rsp_if rsp_bus();
   dwpb_csr_if csr_bus();

   diagonal_weight_pixel_blend_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Local copy of the two size registers, already saturated.
   logic [DIM_W-1:0] rows_setting;
   logic [DIM_W-1:0] cols_setting;

   pixel_pair_type   pixel_queue[$];      // pairs waiting to be driven
   blend_result_type expected_blends[$];  // blends owed by the block, oldest first
   pixel_pair_type   next_pair;
   blend_result_type got_blend;
   blend_result_type want_blend;
   bit               req_busy;            // a request beat is on the bus, not yet taken
   bit               no_idle;             // both sides run flat out while set
   int               blend_errors;

   // --------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------
   function automatic logic [DIM_W-1:0] saturate_dim(int value);
      logic [DIM_W-1:0] v;
      v = value[DIM_W-1:0];
      if (v > DIM_W'(MAX_DIM))
         v = DIM_W'(MAX_DIM);
      return v;
   endfunction

   // Weight for the horizontal pixel is a/(a+b): a is the distance to the
   // top or bottom edge, b to the left or right edge, by quadrant. The
   // split point R/2 (integer halving) belongs to the top/left quadrant.
   function automatic blend_result_type predict_blend(pixel_pair_type p,
                                                      logic [DIM_W-1:0] rows,
                                                      logic [DIM_W-1:0] cols);
      logic [DIM_W-1:0] wa;
      logic [DIM_W-1:0] wb;
      logic [DIM_W:0]   den;
      logic [31:0]      num;
      blend_result_type r;
      r.src = p;
      r.err = 1'b0;
      r.pixel = '0;
      // outside the image (also every pixel when a size is zero)
      if (DIM_W'(p.row) >= rows || DIM_W'(p.col) >= cols) begin
         r.err = 1'b1;
         return r;
      end
      wa = (DIM_W'(p.row) <= (rows >> 1)) ? DIM_W'(p.row) : rows - DIM_W'(p.row);
      wb = (DIM_W'(p.col) <= (cols >> 1)) ? DIM_W'(p.col) : cols - DIM_W'(p.col);
      den = (DIM_W+1)'(wa) + (DIM_W+1)'(wb);
      // weight sum zero only at the origin: horizontal pixel passes through
      if (den == '0) begin
         r.pixel = p.horiz;
      end else begin
         num = 32'(p.horiz) * 32'(wa) + 32'(p.vert) * 32'(wb);
         r.pixel = PIX_W'(num / 32'(den));
      end
      return r;
   endfunction

   // --------------------------------------------------------------------
   // Request driver: new beat at the falling edge, acceptance at the rising.
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_blends = {expected_blends,
                            predict_blend({req_bus.row, req_bus.col,
                                           req_bus.horiz_pixel,
                                           req_bus.vert_pixel},
                                          rows_setting, cols_setting)};
         req_busy = 1'b0;
      end
   end

   // valid is held while a beat waits; only touched once the bus is free
   always @(negedge clock) begin
      if (!reset && !req_busy) begin
         if (pixel_queue.size() != 0 && (no_idle || $urandom_range(99) >= 12)) begin
            next_pair = pixel_queue.pop_front();
            req_bus.row <= next_pair.row;
            req_bus.col <= next_pair.col;
            req_bus.horiz_pixel <= next_pair.horiz;
            req_bus.vert_pixel <= next_pair.vert;
            req_bus.valid <= 1'b1;
            req_busy = 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------
   // Response monitor: random backpressure, in-order compare.
   // --------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (no_idle || $urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_blend.pixel = rsp_bus.blended_pixel;
         got_blend.err = rsp_bus.coord_error;
         if (expected_blends.size() == 0) begin
            blend_errors++;
            if (blend_errors <= 10)
               $display("unexpected rsp beat: pixel %h err %b", got_blend.pixel,
                        got_blend.err);
         end else begin
            want_blend = expected_blends.pop_front();
            if (got_blend.pixel !== want_blend.pixel || got_blend.err !== want_blend.err) begin
               blend_errors++;
               if (blend_errors <= 10)
                  $display("blend mismatch row %0d col %0d x %h y %h: exp %h/%b got %h/%b",
                           want_blend.src.row, want_blend.src.col, want_blend.src.horiz,
                           want_blend.src.vert, want_blend.pixel, want_blend.err,
                           got_blend.pixel, got_blend.err);
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------
   task automatic add_pair(int row, int col, int horiz, int vert);
      pixel_pair_type p;
      p.row = row[COORD_W-1:0];
      p.col = col[COORD_W-1:0];
      p.horiz = horiz[PIX_W-1:0];
      p.vert = vert[PIX_W-1:0];
      pixel_queue = {pixel_queue, p};
   endtask

   // Mostly inside the image, with weight on the edges, the quadrant split
   // and the first coordinates just past the end.
   function automatic int pick_coord(int dim);
      int sel;
      int v;
      sel = $urandom_range(9);
      if (sel == 0 || dim == 0)
         v = $urandom_range(4095);
      else if (sel == 1)
         v = dim / 2 + $urandom_range(2) - 1;
      else if (sel == 2)
         v = $urandom_range(1) ? dim - 1 : 0;
      else if (sel == 3)
         v = dim + $urandom_range(3);
      else
         v = $urandom_range(dim - 1);
      return v;
   endfunction

   function automatic int pick_pixel();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0)
         return 0;
      else if (sel == 1)
         return 16'hFFFF;
      return $urandom_range(16'hFFFF);
   endfunction

   task automatic add_random_pairs(int count);
      repeat (count)
         add_pair(pick_coord(rows_setting), pick_coord(cols_setting), pick_pixel(),
                  pick_pixel());
   endtask

   // Block idle: nothing queued, nothing on the bus, nothing owed, and the
   // pipeline (7 stages) given time to settle.
   task automatic wait_drained();
      while (pixel_queue.size() != 0 || req_busy || expected_blends.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_dim(csr_idx_type idx, int value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value[DIM_W-1:0];
      do
         @(posedge clock);
      while (!csr_bus.ready);
      if (idx == CSR_IMAGE_ROWS)
         rows_setting = saturate_dim(value);
      else
         cols_setting = saturate_dim(value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(int rows, int cols, int count);
      wait_drained();
      write_dim(CSR_IMAGE_ROWS, rows);
      write_dim(CSR_IMAGE_COLS, cols);
      add_random_pairs(count);
   endtask

   // --------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.row = '0;
      req_bus.col = '0;
      req_bus.horiz_pixel = '0;
      req_bus.vert_pixel = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_IMAGE_ROWS;
      csr_bus.data = '0;
      rows_setting = saturate_dim(MAX_DIM);
      cols_setting = saturate_dim(MAX_DIM);
      req_busy = 1'b0;
      no_idle = 1'b0;
      blend_errors = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, at the reset size 4096 x 4096.
      add_pair(0, 0, 16'hFFFF, 16'h0000);       // origin: horizontal pixel only
      add_pair(0, 0, 16'h0000, 16'hFFFF);
      add_pair(0, 4095, 16'h1234, 16'hFFFF);    // a = 0: vertical pixel only
      add_pair(4095, 0, 16'hFFFF, 16'h0000);    // b = 0
      add_pair(2048, 2048, 16'hFFFF, 16'h0000); // on the split, largest weights
      add_pair(2049, 2049, 16'hFFFF, 16'hFFFF); // first row/col past the split
      add_pair(2048, 2049, 16'hFFFF, 16'h0001);
      add_pair(2049, 2048, 16'h0001, 16'hFFFF);
      add_pair(4095, 4095, 16'hFFFF, 16'h0000); // far corner, a = b = 1
      add_pair(1, 2, 16'hFFFF, 16'h0000);       // a = 1, b = 2: divisor 3
      add_pair(2, 1, 16'h0000, 16'hFFFF);
      add_pair(0, 1, 16'hABCD, 16'h5555);
      add_pair(1, 0, 16'hABCD, 16'h5555);
      add_pair(4095, 4095, 16'h0000, 16'h0000);
      add_pair(12'hAAA, 12'h555, 16'hAAAA, 16'h5555);
      add_pair(12'h555, 12'hAAA, 16'h5555, 16'hAAAA);
      add_pair(4094, 2, 16'hFFFF, 16'hFFFF);
      add_pair(2047, 4094, 16'h8000, 16'h7FFF);
      add_random_pairs(80);

      // 1 x 1: only the origin lies inside
      run_phase(1, 1, 10);
      add_pair(0, 0, 16'h4321, 16'h8765);
      add_pair(1, 0, 16'hFFFF, 16'hFFFF);
      add_pair(0, 1, 16'hFFFF, 16'hFFFF);

      // zero rows: everything flagged
      run_phase(0, 7, 15);

      // writes above the limit saturate to 4096
      run_phase(8191, 4097, 40);

      // tiny image, with directed edges just outside
      run_phase(2, 3, 25);
      add_pair(2, 0, 16'hFFFF, 16'hFFFF);
      add_pair(0, 3, 16'hFFFF, 16'hFFFF);
      add_pair(4095, 4095, 16'hFFFF, 16'hFFFF);

      // long stretch with no idling on either side
      wait_drained();
      no_idle = 1'b1;
      run_phase($urandom_range(1, 64), $urandom_range(1, 64), 100);
      wait_drained();
      no_idle = 1'b0;

      // extreme aspect ratios
      run_phase(4096, 1, 30);
      run_phase(13, 4096, 30);

      // arbitrary sizes, including raw values above the limit
      run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 30);
      run_phase($urandom_range(0, 8191), $urandom_range(1, 4096), 30);

      wait_drained();
      if (blend_errors == 0 && expected_blends.size() == 0) begin
         $display("diagonal_weight_pixel_blend_unit test passed");
      end else begin
         $display("diagonal_weight_pixel_blend_unit test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of 414 beats.
   initial begin
      #2000000;
      $display("diagonal_weight_pixel_blend_unit test failed");
      $finish;
   end

endmodule

@@ files.f @@
design/dwpb_pkg.sv
design/dwpb_req_if.sv
design/dwpb_rsp_if.sv
design/dwpb_csr_if.sv
design/dwpb_csr.sv
design/dwpb_wgt.sv
design/dwpb_mul.sv
design/dwpb_div.sv
design/diagonal_weight_pixel_blend_unit.sv
bench/tb.sv
